### sv/pcdp_pkg.sv
package pcdp_pkg;

    typedef enum logic [2:0] {
        CMD_LINE  = 3'd0,
        CMD_MOVE  = 3'd1,
        CMD_RMOVE = 3'd2,
        CMD_HREL  = 3'd3,
        CMD_HABS  = 3'd4,
        CMD_VREL  = 3'd5,
        CMD_VABS  = 3'd6,
        CMD_CLOSE = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_APPLY
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PREP,
        B_EMIT
    } t_back_state;

    // One drawn segment waiting for its depth passes.
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] za;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] zb;
    } t_seg;

    // Occupancy of the segment queue as seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [1:0] REG_PX_RATIO    = 2'd0;
    localparam logic [1:0] REG_PAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PASS_STEP   = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int OUT_DATA_W = 200;

    localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

    function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
        return {{8{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/pcdp_front.sv
module pcdp_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  pcdp_pkg::t_cmd          i_cmd,
    input  logic signed [31:0]      i_arg_x,
    input  logic signed [31:0]      i_arg_y,
    input  logic signed [31:0]      i_cut_depth,
    input  logic [17:0]             i_px_ratio,
    input  logic [30:0]             i_page_height,
    input  pcdp_pkg::t_q_stat       i_q_stat,
    output logic                    o_push,
    output pcdp_pkg::t_seg          o_seg
);
    import pcdp_pkg::*;

    t_front_state r_state, n_state;

    t_cmd               r_cmd;
    logic signed [31:0] r_ax, r_ay, r_z;
    logic signed [51:0] r_prod_x, r_prod_y;
    logic signed [51:0] n_prod_x, n_prod_y;

    logic signed [31:0] r_cur_x, r_cur_y, r_cur_z;
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic               r_first;

    logic signed [32:0] w_mx_op, w_my_op;
    logic signed [18:0] w_ratio;
    logic signed [31:0] w_mm_x, w_mm_y;
    logic signed [31:0] w_tx, w_ty, w_tz;
    logic               w_draw, w_emit, w_commit;

    // Operands of the two page-unit to millimetre products.
    always_comb begin
        if (r_cmd inside {CMD_VREL, CMD_VABS}) begin
            w_mx_op = -{r_ax[31], r_ax};
        end else begin
            w_mx_op = {r_ax[31], r_ax};
        end
        if (r_cmd == CMD_MOVE) begin
            w_my_op = {r_ay[31], r_ay};
        end else begin
            w_my_op = {2'b00, i_page_height} - {r_ay[31], r_ay};
        end
    end

    assign w_ratio  = {1'b0, i_px_ratio};
    assign n_prod_x = w_mx_op * w_ratio;
    assign n_prod_y = w_my_op * w_ratio;

    // The arithmetic shift of the product is the floor of the Q2.16 scaling.
    assign w_mm_x = sat32({{4{r_prod_x[51]}}, r_prod_x[51:16]});
    assign w_mm_y = sat32({{4{r_prod_y[51]}}, r_prod_y[51:16]});

    always_comb begin
        w_tx = w_mm_x;
        w_ty = w_mm_y;
        w_tz = r_z;
        case (r_cmd)
            CMD_LINE: begin
            end
            CMD_MOVE: begin
            end
            CMD_RMOVE: begin
                w_ty = sat32(ext40(w_mm_y) + ext40(r_cur_y));
            end
            CMD_HREL: begin
                w_tx = sat32(ext40(w_mm_x) + ext40(r_cur_x));
                w_ty = r_cur_y;
            end
            CMD_HABS: begin
                w_ty = r_cur_y;
            end
            CMD_VREL: begin
                w_tx = r_cur_x;
                w_ty = sat32(ext40(w_mm_x) + ext40(r_cur_y));
            end
            CMD_VABS: begin
                w_tx = r_cur_x;
                w_ty = w_mm_x;
            end
            CMD_CLOSE: begin
                w_tx = r_org_x;
                w_ty = r_org_y;
                w_tz = r_org_z;
            end
            default: begin
            end
        endcase
    end

    assign w_draw = (r_cmd != CMD_MOVE) && (r_cmd != CMD_RMOVE);
    // Segments that stay at or above zero along both ends need no pass.
    assign w_emit = w_draw && !r_first && (r_cur_z[31] || w_tz[31]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_APPLY;
            end
            F_APPLY: begin
                if (!(w_emit && i_q_stat.full)) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready  = (r_state == F_IDLE);
        w_commit = (r_state == F_APPLY) && !(w_emit && i_q_stat.full);
        o_push   = w_commit && w_emit;
    end

    assign o_seg.x1 = r_cur_x;
    assign o_seg.y1 = r_cur_y;
    assign o_seg.za = r_cur_z;
    assign o_seg.x2 = w_tx;
    assign o_seg.y2 = w_ty;
    assign o_seg.zb = w_tz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_cur_z <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_cur_x <= w_tx;
                r_cur_y <= w_ty;
                r_cur_z <= w_tz;
                if (!w_draw) begin
                    r_org_x <= w_tx;
                    r_org_y <= w_ty;
                    r_org_z <= w_tz;
                end
                r_first <= (r_cmd == CMD_CLOSE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
            r_ax  <= i_arg_x;
            r_ay  <= i_arg_y;
            r_z   <= i_cut_depth;
        end
        if (r_state == F_MUL) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
    end

endmodule

### sv/pcdp_queue.sv
module pcdp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcdp_pkg::t_seg      i_seg,
    input  logic                i_pop,
    output pcdp_pkg::t_seg      o_seg,
    output pcdp_pkg::t_q_stat   o_stat
);
    import pcdp_pkg::*;

    t_seg              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_seg        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_seg;
        end
    end

endmodule

### sv/pcdp_back.sv
module pcdp_back #(
    parameter int MAX_PASSES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [30:0]                         i_pass_step,
    input  pcdp_pkg::t_q_stat                   i_q_stat,
    input  pcdp_pkg::t_seg                      i_seg,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pcdp_pkg::OUT_DATA_W-1:0]     o_data,
    output logic                                o_last,
    output logic                                o_trunc
);
    import pcdp_pkg::*;

    t_back_state r_state, n_state;

    logic signed [31:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [39:0] r_za, r_zb;
    logic [6:0]         r_level;
    logic               r_trunc;

    logic signed [39:0] w_step, w_na, w_nb, w_zmin, w_deep;
    logic               w_last, w_load;

    assign w_step = {9'b0, i_pass_step};
    assign w_na   = r_za + w_step;
    assign w_nb   = r_zb + w_step;
    assign w_last = (r_level == 7'(MAX_PASSES)) || (!w_na[39] && !w_nb[39]);

    // Passes are cut off exactly when the deeper end is still below zero
    // after the full count of raises.
    assign w_zmin = (r_za < r_zb) ? r_za : r_zb;
    assign w_deep = w_zmin + w_step * 40'(MAX_PASSES);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = B_PREP;
                end
            end
            B_PREP: begin
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (i_ready && w_last) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        w_load  = (r_state == B_IDLE) && !i_q_stat.empty;
        o_pop   = w_load;
        o_valid = (r_state == B_EMIT);
        o_last  = w_last;
        o_trunc = r_trunc;
    end

    assign o_data = {1'b0, sat32(r_zb), r_y2, r_x2, sat32(r_za), r_y1, r_x1, r_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x1    <= i_seg.x1;
            r_y1    <= i_seg.y1;
            r_x2    <= i_seg.x2;
            r_y2    <= i_seg.y2;
            r_za    <= ext40(i_seg.za);
            r_zb    <= ext40(i_seg.zb);
            r_level <= 7'd1;
        end else if (r_state == B_EMIT && i_ready && !w_last) begin
            r_za    <= w_na;
            r_zb    <= w_nb;
            r_level <= r_level + 7'd1;
        end
        if (r_state == B_PREP) begin
            r_trunc <= w_deep[39];
        end
    end

endmodule

### sv/path_command_to_depth_passes.sv
// Path command to depth passes.
// Input stream: one beat per path command. tuser carries the command code,
// tdata carries arg_x, arg_y and cut_depth. A drawn segment whose Z ends are
// not both at or above zero leaves on the output stream once per depth pass,
// Z raised by pass_step each pass, up to MAX_PASSES beats; tlast marks the
// final beat of a command and tuser flags a command whose passes were cut off.
// The configuration port takes px_ratio (0), page_height (1) and pass_step (2)
// and may only be written while no command is in flight.
// The front takes one command at a time (capture, scaling multiply, state
// update) and accepts the next only when idle; a push into a full queue holds
// it in the update step. The back loads a segment (pop, then prepare) and then
// emits one pass per cycle while tready is high. With an empty queue a first
// beat follows capture, multiply, update, queue write, load and prepare.
// A four-entry segment queue sits between the two, so a stalled output keeps
// its beat stable while the front continues until it must push into a full
// queue, which keeps tready low. Reset restores the default configuration,
// clears the current and start points and marks the first point as pending.
module path_command_to_depth_passes #(
    parameter int MAX_PASSES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,  // arg_x, arg_y, cut_depth
    input  logic [2:0]   i_s_axis_tuser,  // cmd
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // level, x_start, y_start, z_start, x_end, y_end, z_end, zero pad
    output logic [199:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,  // last_pass
    output logic         o_m_axis_tuser,  // truncated
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_wdata
);
    import pcdp_pkg::*;

    logic [17:0] r_px_ratio;
    logic [30:0] r_page_height;
    logic [30:0] r_pass_step;

    logic    w_push, w_pop;
    t_seg    w_push_seg, w_pop_seg;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_ratio    <= 18'd17340;
            r_page_height <= 31'd0;
            r_pass_step   <= 31'd6554;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PX_RATIO:    r_px_ratio    <= i_cfg_wdata[17:0];
                REG_PAGE_HEIGHT: r_page_height <= i_cfg_wdata;
                REG_PASS_STEP:   r_pass_step   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pcdp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_cmd         (t_cmd'(i_s_axis_tuser)),
        .i_arg_x       (i_s_axis_tdata[31:0]),
        .i_arg_y       (i_s_axis_tdata[63:32]),
        .i_cut_depth   (i_s_axis_tdata[95:64]),
        .i_px_ratio    (r_px_ratio),
        .i_page_height (r_page_height),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_seg         (w_push_seg)
    );

    pcdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_seg   (w_push_seg),
        .i_pop   (w_pop),
        .o_seg   (w_pop_seg),
        .o_stat  (w_q_stat)
    );

    pcdp_back #(
        .MAX_PASSES (MAX_PASSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pass_step (r_pass_step),
        .i_q_stat    (w_q_stat),
        .i_seg       (w_pop_seg),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_trunc     (o_m_axis_tuser)
    );

    // Every beat sent carries at least one end below zero.
    a_depth_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[102] || o_m_axis_tdata[198]))
        else $error("pass sent with both Z ends at or above zero");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[6:0] != 7'd0 && o_m_axis_tdata[6:0] <= 7'(MAX_PASSES)))
        else $error("pass number out of range");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && o_m_axis_tdata[6:0] == $past(o_m_axis_tdata[6:0]) + 7'd1))
        else $error("pass number did not advance by one within a command");

    a_trunc_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && o_m_axis_tuser) |->
            (o_m_axis_tdata[6:0] == 7'(MAX_PASSES)))
        else $error("truncated command ended before the pass cap");

endmodule
